### hw/rtl/stbd_pkg.sv
// shared definitions for the shared-timer button debouncer
package stbd_pkg;

  localparam int CNT_W = 16;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef logic [CNT_W-1:0] cnt_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_LONG     = 1'b1
  } reg_idx_t;

  localparam cnt_t DEBOUNCE_RESET = 16'd135;
  localparam cnt_t LONG_RESET     = 16'd1350;

endpackage

### hw/rtl/stbd_in_if.sv
// input channel: one word of raw button levels
interface stbd_in_if #(
  parameter int NUM_KEYS = 5
);
  logic                valid;
  logic                ready;
  logic [NUM_KEYS-1:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink (input valid, input pin_levels, output ready);
endinterface

### hw/rtl/stbd_out_if.sv
// output channel: one word of press events and debounced flags
interface stbd_out_if #(
  parameter int NUM_KEYS = 5
);
  logic                valid;
  logic                ready;
  logic [NUM_KEYS-1:0] short_press;
  logic [NUM_KEYS-1:0] long_press;
  logic [NUM_KEYS-1:0] pressed;

  modport source (output valid, output short_press, output long_press, output pressed,
                  input ready);
  modport sink (input valid, input short_press, input long_press, input pressed,
                output ready);
endinterface

### hw/rtl/shared_timer_button_debouncer.sv
// Shared-timer button debouncer with short and long press detection.
//
// Each word on the sample channel is one tick of raw, active-high button
// levels. One debounce timer and one long-press timer are shared by all
// buttons; the first button (lowest index) whose level differs from its
// debounced flag claims the debounce timer while it is idle.
// Each accepted word yields exactly one word on the result channel:
// short_press and long_press pulses plus the debounced pressed flags.
// The sample is registered at acceptance and its result word is registered
// in the result register when that register is free or being taken.
// Throughput: one word per cycle while results are taken; all per-tick
// work is a single pass of logic between the input and result registers.
// When the receiver stalls, the result register holds and the input
// register takes one more word, then sample.ready drops until the result
// is taken.
// Configuration: APB writes to debounce_ticks (0x0) and long_press_ticks
// (0x4), low 16 bits used; pready is always high. Write only while idle.
// Reset (rst, synchronous): timers stopped, all buttons released, both
// registers back to 135 and 1350, no word held.
module shared_timer_button_debouncer #(
  parameter int NUM_KEYS = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [stbd_pkg::APB_AW-1:0] paddr,
  input  logic [stbd_pkg::APB_DW-1:0] pwdata,
  output logic [stbd_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  stbd_in_if.sink                   sample,
  stbd_out_if.source                result
);

  typedef logic [NUM_KEYS-1:0] keys_t;

  // configuration
  stbd_pkg::cnt_t   debounce_ticks;
  stbd_pkg::cnt_t   long_press_ticks;
  stbd_pkg::reg_idx_t cfg_idx;
  logic             cfg_wr;

  // input register
  logic  in_valid;
  keys_t in_levels;
  logic  advance;

  // block state
  stbd_pkg::cnt_t debounce_count, debounce_count_next;
  logic           debounce_running, debounce_running_next;
  stbd_pkg::cnt_t long_count, long_count_next;
  logic           long_running, long_running_next;
  keys_t          pressed_flags, pressed_flags_next;
  keys_t          claim_flags, claim_flags_next;
  keys_t          long_flags, long_flags_next;

  // result register
  logic  out_valid;
  keys_t out_short, out_long, out_pressed;
  keys_t shorts, longs;

  // poll and timer intermediates
  keys_t          diff, first_diff;
  logic           ripple, claim_prs;
  stbd_pkg::cnt_t p_cnt, p_lcnt, d_cnt, l_cnt;
  logic           p_run, p_lrun, d_exp, l_exp;
  keys_t          p_claim, rel, set_prs, long_mid;

  assign pready  = 1'b1;
  assign cfg_idx = stbd_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= stbd_pkg::DEBOUNCE_RESET;
      long_press_ticks <= stbd_pkg::LONG_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        stbd_pkg::REG_DEBOUNCE: debounce_ticks   <= pwdata[stbd_pkg::CNT_W-1:0];
        stbd_pkg::REG_LONG:     long_press_ticks <= pwdata[stbd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      stbd_pkg::REG_DEBOUNCE: prdata = {{(stbd_pkg::APB_DW-stbd_pkg::CNT_W){1'b0}},
                                        debounce_ticks};
      stbd_pkg::REG_LONG:     prdata = {{(stbd_pkg::APB_DW-stbd_pkg::CNT_W){1'b0}},
                                        long_press_ticks};
      default:                prdata = '0;
    endcase
  end

  // handshake
  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      in_levels <= sample.pin_levels;
    end
  end

  // one tick of work
  always_comb begin
    diff       = in_levels ^ pressed_flags;
    // lowest set bit of diff
    first_diff = diff & (~diff + keys_t'(1));
    ripple     = |(claim_flags & ~diff);
    claim_prs  = |(claim_flags & pressed_flags);

    p_run   = debounce_running;
    p_cnt   = debounce_count;
    p_claim = claim_flags;
    p_lrun  = long_running;
    p_lcnt  = long_count;
    if (!debounce_running) begin
      if (|diff) begin
        p_run   = 1'b1;
        p_cnt   = '0;
        p_claim = first_diff;
        if (|(first_diff & in_levels)) begin
          p_lrun = 1'b1;
          p_lcnt = '0;
        end
      end
    end else if (ripple) begin
      p_cnt = '0;
      if (!claim_prs) begin
        p_lcnt = '0;
      end
    end

    d_cnt   = p_cnt + stbd_pkg::cnt_t'(1);
    d_exp   = p_run && (d_cnt >= debounce_ticks);
    rel     = p_claim & pressed_flags & ~in_levels;
    set_prs = p_claim & ~pressed_flags & in_levels;

    debounce_running_next = p_run;
    debounce_count_next   = p_run ? d_cnt : p_cnt;
    claim_flags_next      = p_claim;
    pressed_flags_next    = pressed_flags;
    long_mid              = long_flags;
    shorts                = '0;
    if (d_exp) begin
      pressed_flags_next    = (pressed_flags | set_prs) & ~rel;
      shorts                = rel & ~long_flags;
      long_mid              = long_flags & ~rel;
      claim_flags_next      = '0;
      debounce_running_next = 1'b0;
      debounce_count_next   = '0;
    end

    l_cnt = p_lcnt + stbd_pkg::cnt_t'(1);
    l_exp = p_lrun && (l_cnt >= long_press_ticks);
    long_running_next = p_lrun;
    long_count_next   = p_lrun ? l_cnt : p_lcnt;
    longs             = '0;
    if (l_exp) begin
      longs             = pressed_flags_next;
      long_running_next = 1'b0;
      long_count_next   = '0;
    end
    long_flags_next = long_mid | longs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count   <= '0;
      debounce_running <= 1'b0;
      long_count       <= '0;
      long_running     <= 1'b0;
      pressed_flags    <= '0;
      claim_flags      <= '0;
      long_flags       <= '0;
    end else if (advance) begin
      debounce_count   <= debounce_count_next;
      debounce_running <= debounce_running_next;
      long_count       <= long_count_next;
      long_running     <= long_running_next;
      pressed_flags    <= pressed_flags_next;
      claim_flags      <= claim_flags_next;
      long_flags       <= long_flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_short   <= shorts;
      out_long    <= longs;
      out_pressed <= pressed_flags_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.short_press = out_short;
  assign result.long_press  = out_long;
  assign result.pressed     = out_pressed;

  // at most one button holds the debounce timer
  a_claim_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(claim_flags))
    else $error("more than one debounce claimant");

  // a claim exists exactly while the debounce timer runs
  a_claim_running: assert property (@(posedge clk) disable iff (rst)
    debounce_running == (claim_flags != '0))
    else $error("claim flags out of step with debounce timer");

  // a short press is reported only for a button that is now released
  a_short_released: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_short & out_pressed) == '0))
    else $error("short press on a pressed button");

  // a long press is reported only for a pressed button
  a_long_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_long & ~out_pressed) == '0))
    else $error("long press on a released button");

  // a stalled result blocks new input while the input register is full
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready && in_valid) |-> !sample.ready)
    else $error("input taken while both registers are full");

endmodule

### verif/tb_shared_timer_button_debouncer.sv
// testbench for the shared-timer button debouncer: directed rows, then random press sequences
`timescale 1ns / 100ps

module tb_shared_timer_button_debouncer;

  localparam int NUM_KEYS = 5;
  localparam int STALL_LIMIT = 4000;

  typedef logic [NUM_KEYS-1:0] keys_t;

  typedef struct packed {
    keys_t short_press;
    keys_t long_press;
    keys_t pressed;
  } press_word_t;

  // one directed row: a register write, or a word of pin levels
  typedef struct packed {
    bit                 is_cfg;
    stbd_pkg::reg_idx_t idx;
    stbd_pkg::cnt_t     value;
    keys_t              pins;
    bit                 typed;
    press_word_t        want;
  } stim_row_t;

  localparam press_word_t NO_EVENTS = '0;
  localparam int NUM_ROWS = 28;

  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    // after reset: a press is only claimed, nothing can expire yet
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00000, 1'b1, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b11111, 1'b1, NO_EVENTS},
    '{1'b1, stbd_pkg::REG_DEBOUNCE, 16'd2, 5'b00000, 1'b0, NO_EVENTS},
    '{1'b1, stbd_pkg::REG_LONG,     16'd5, 5'b00000, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00000, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00000, 1'b0, NO_EVENTS},
    // press with ripple, held into a long press
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00001, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00000, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00001, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00001, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00001, 1'b0, NO_EVENTS},
    // second press while the first button still holds the debounce timer: no events
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00011, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00011, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00011, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00011, 1'b0, NO_EVENTS},
    // release after long press: no short pulse
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00010, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00010, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00000, 1'b0, NO_EVENTS},
    // button 2 toggles while button 1 still holds the debounce timer: no events
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00100, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00100, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00000, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00100, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00000, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00000, 1'b0, NO_EVENTS},
    // zero debounce value acts as one
    '{1'b1, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00000, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b11111, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00000, 1'b0, NO_EVENTS},
    '{1'b0, stbd_pkg::REG_DEBOUNCE, 16'd0, 5'b00000, 1'b0, NO_EVENTS}
  };

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [stbd_pkg::APB_AW-1:0] paddr;
  logic [stbd_pkg::APB_DW-1:0] pwdata;
  logic [stbd_pkg::APB_DW-1:0] prdata;
  logic pready;

  stbd_in_if #(.NUM_KEYS(NUM_KEYS)) sample_if ();
  stbd_out_if #(.NUM_KEYS(NUM_KEYS)) result_if ();

  shared_timer_button_debouncer #(.NUM_KEYS(NUM_KEYS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_if),
    .result  (result_if)
  );

  // debouncer state as the block should hold it
  stbd_pkg::cnt_t debounce_limit = stbd_pkg::DEBOUNCE_RESET;
  stbd_pkg::cnt_t long_limit = stbd_pkg::LONG_RESET;
  stbd_pkg::cnt_t debounce_cnt = '0;
  bit             debounce_run = 1'b0;
  stbd_pkg::cnt_t long_cnt = '0;
  bit             long_run = 1'b0;
  keys_t          held_keys = '0;
  keys_t          claim_keys = '0;
  keys_t          long_keys = '0;

  press_word_t pending_events [$];
  keys_t button_levels = '0;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic press_word_t debounce_tick(input keys_t lv);
    press_word_t w;
    keys_t shorts;
    keys_t longs;
    shorts = '0;
    longs = '0;
    // poll in index order, a claim blocks the later buttons
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (!debounce_run) begin
        if (lv[i] != held_keys[i]) begin
          debounce_run = 1'b1;
          debounce_cnt = '0;
          claim_keys[i] = 1'b1;
          if (lv[i]) begin
            long_run = 1'b1;
            long_cnt = '0;
          end
        end
      end else if (claim_keys[i] && lv[i] == held_keys[i]) begin
        debounce_cnt = '0;
        if (!held_keys[i]) long_cnt = '0;
      end
    end
    if (debounce_run) begin
      debounce_cnt = debounce_cnt + 1'b1;
      if (debounce_cnt >= debounce_limit) begin
        for (int i = 0; i < NUM_KEYS; i++) begin
          if (claim_keys[i]) begin
            if (!held_keys[i] && lv[i]) begin
              held_keys[i] = 1'b1;
            end else if (held_keys[i] && !lv[i]) begin
              held_keys[i] = 1'b0;
              if (long_keys[i]) long_keys[i] = 1'b0;
              else shorts[i] = 1'b1;
            end
          end
        end
        claim_keys = '0;
        debounce_run = 1'b0;
        debounce_cnt = '0;
      end
    end
    if (long_run) begin
      long_cnt = long_cnt + 1'b1;
      if (long_cnt >= long_limit) begin
        longs = held_keys;
        long_keys |= held_keys;
        long_run = 1'b0;
        long_cnt = '0;
      end
    end
    w.short_press = shorts;
    w.long_press = longs;
    w.pressed = held_keys;
    return w;
  endfunction

  task automatic apb_access(input bit wr, input stbd_pkg::reg_idx_t idx,
                            input stbd_pkg::cnt_t wdata,
                            output logic [stbd_pkg::APB_DW-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {{(stbd_pkg::APB_DW-stbd_pkg::CNT_W){1'b0}}, wdata};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    rdata = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(input stbd_pkg::reg_idx_t idx, input stbd_pkg::cnt_t want);
    logic [stbd_pkg::APB_DW-1:0] rdata;
    apb_access(1'b0, idx, '0, rdata);
    if (rdata !== {{(stbd_pkg::APB_DW-stbd_pkg::CNT_W){1'b0}}, want}) begin
      errors++;
      $display("%0t: register %s expected %0d, got %0d", $time, idx.name(), want, rdata);
    end
  endtask

  task automatic write_reg(input stbd_pkg::reg_idx_t idx, input stbd_pkg::cnt_t value);
    logic [stbd_pkg::APB_DW-1:0] rdata;
    apb_access(1'b1, idx, value, rdata);
    if (idx == stbd_pkg::REG_DEBOUNCE) debounce_limit = value;
    else long_limit = value;
    check_reg(idx, value);
  endtask

  // holds valid low until every result word has come back
  task automatic wait_for_results();
    sample_if.valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  task automatic send_pins(input keys_t lv, input bit typed, input press_word_t want);
    press_word_t calc;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.pin_levels <= lv;
    do @(posedge clk); while (!sample_if.ready);
    calc = debounce_tick(lv);
    pending_events.push_back(typed ? want : calc);
  endtask

  task automatic run_phase(input stbd_pkg::cnt_t db, input stbd_pkg::cnt_t lp,
                           input int send_pct, input int recv_pct, input int count);
    keys_t word;
    int k;
    wait_for_results();
    write_reg(stbd_pkg::REG_DEBOUNCE, db);
    write_reg(stbd_pkg::REG_LONG, lp);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_for_results();
      k = $urandom_range(NUM_KEYS - 1);
      case ($urandom_range(31))
        0, 1, 2: begin
          button_levels[k] = ~button_levels[k];
          word = button_levels;
        end
        3, 4: word = button_levels ^ keys_t'(1 << k);  // one-word ripple
        5: word = keys_t'($urandom);
        default: word = button_levels;
      endcase
      send_pins(word, 1'b0, NO_EVENTS);
    end
  endtask

  // result side: random stalls and the field compare
  always @(posedge clk) begin
    press_word_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, got %b %b %b", $time,
                 result_if.short_press, result_if.long_press, result_if.pressed);
      end else begin
        want = pending_events.pop_front();
        if (result_if.short_press !== want.short_press) begin
          errors++;
          $display("%0t: short_press expected %b, got %b", $time, want.short_press,
                   result_if.short_press);
        end
        if (result_if.long_press !== want.long_press) begin
          errors++;
          $display("%0t: long_press expected %b, got %b", $time, want.long_press,
                   result_if.long_press);
        end
        if (result_if.pressed !== want.pressed) begin
          errors++;
          $display("%0t: pressed expected %b, got %b", $time, want.pressed,
                   result_if.pressed);
        end
      end
    end
    result_if.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || psel || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_if.valid = 1'b0;
    sample_if.pin_levels = '0;
    result_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    check_reg(stbd_pkg::REG_DEBOUNCE, stbd_pkg::DEBOUNCE_RESET);
    check_reg(stbd_pkg::REG_LONG, stbd_pkg::LONG_RESET);

    send_idle_pct = 32;
    recv_idle_pct = 84;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (STIM_ROWS[r].is_cfg) begin
        wait_for_results();
        write_reg(STIM_ROWS[r].idx, STIM_ROWS[r].value);
      end else begin
        send_pins(STIM_ROWS[r].pins, STIM_ROWS[r].typed, STIM_ROWS[r].want);
      end
    end
    button_levels = '0;

    run_phase(16'd3, 16'd12, 32, 84, 90);
    run_phase(16'd1, 16'd1, 32, 84, 90);
    run_phase(stbd_pkg::cnt_t'($urandom_range(1, 6)),
              stbd_pkg::cnt_t'($urandom_range(2, 40)), 84, 32, 95);
    run_phase(16'hFFFF, 16'hFFFF, 84, 32, 60);
    run_phase(16'd2, 16'hFFFF, 0, 0, 95);
    run_phase(stbd_pkg::cnt_t'($urandom_range(1, 4)),
              stbd_pkg::cnt_t'($urandom_range(1, 16)), 0, 0, 120);

    wait_for_results();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### shared_timer_button_debouncer.f
hw/rtl/stbd_pkg.sv
hw/rtl/stbd_in_if.sv
hw/rtl/stbd_out_if.sv
hw/rtl/shared_timer_button_debouncer.sv
verif/tb_shared_timer_button_debouncer.sv
